// ----- hdl/bba_pkg.sv -----
package bba_pkg;

    localparam int WORD_W       = 32;
    localparam int BIT_W        = 5;
    localparam int SIZE_W       = 10;
    localparam int INDEX_W      = 9;
    localparam int STATUS_W     = 2;
    localparam int FIRST_USABLE = 2;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 10'd512;

    // blocks 0 and 1 are reserved, so word 0 comes out of reset with them set
    localparam logic [WORD_W-1:0] WORD0_RESET = 32'h0000_0003;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_FREE   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 2'd2;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef struct packed {
        logic               opcode;
        logic [INDEX_W-1:0] block_index;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [INDEX_W-1:0]  allocated_index;
    } rsp_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FREE,
        S_SCAN
    } state_t;

    // lowest set bit of a word
    function automatic logic [BIT_W-1:0] first_one(input logic [WORD_W-1:0] v);
        logic [BIT_W-1:0] pos;
        pos = '0;
        for (int i = WORD_W - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                pos = BIT_W'(i);
            end
        end
        return pos;
    endfunction

endpackage

// ----- hdl/bba_map_ram.sv -----
module bba_map_ram
    import bba_pkg::*;
#(
    parameter int MAX_BLOCKS = 512,
    localparam int NUM_WORDS = (MAX_BLOCKS + WORD_W - 1) / WORD_W,
    localparam int WADDR_W   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rd_en,
    input  logic [WADDR_W-1:0] rd_addr,
    output logic [WORD_W-1:0] rd_data,
    input  logic              wr_en,
    input  logic [WADDR_W-1:0] wr_addr,
    input  logic [WORD_W-1:0] wr_data
);

    localparam int MEM_DEPTH = 1 << WADDR_W;

    logic [WORD_W-1:0]  mem [MEM_DEPTH];
    logic [WORD_W-1:0]  mem_q_reg;
    logic [MEM_DEPTH-1:0] valid_reg;
    logic               rd_valid_reg;
    logic [WADDR_W-1:0] rd_addr_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            mem_q_reg   <= mem[rd_addr];
            rd_addr_reg <= rd_addr;
        end
    end

    // words never written read as their reset pattern
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    always_comb
    begin
        if (rd_valid_reg)
        begin
            rd_data = mem_q_reg;
        end
        else if (rd_addr_reg == '0)
        begin
            rd_data = WORD0_RESET;
        end
        else
        begin
            rd_data = '0;
        end
    end

endmodule

// ----- hdl/bba_ctrl.sv -----
module bba_ctrl
    import bba_pkg::*;
#(
    parameter int MAX_BLOCKS = 512,
    localparam int NUM_WORDS = (MAX_BLOCKS + WORD_W - 1) / WORD_W,
    localparam int WADDR_W   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1,
    localparam int EFF_W     = ($clog2(MAX_BLOCKS + 1) > SIZE_W) ?
                               $clog2(MAX_BLOCKS + 1) : SIZE_W
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  req_t               req,
    input  logic [EFF_W-1:0]   eff_size,
    output logic               done,
    output rsp_t               rsp,
    output logic               rd_en,
    output logic [WADDR_W-1:0] rd_addr,
    input  logic [WORD_W-1:0]  rd_data,
    output logic               wr_en,
    output logic [WADDR_W-1:0] wr_addr,
    output logic [WORD_W-1:0]  wr_data
);

    localparam int GIDX_W    = (WADDR_W + BIT_W > EFF_W) ? WADDR_W + BIT_W : EFF_W;

    state_t             state_reg, state_next;
    logic [WADDR_W-1:0] fword_reg, fword_next;
    logic [BIT_W-1:0]   fbit_reg, fbit_next;
    logic [WADDR_W:0]   issue_reg, issue_next;
    logic [WADDR_W-1:0] chk_w_reg, chk_w_next;
    logic               chk_vld_reg, chk_vld_next;
    logic               done_reg, done_next;
    rsp_t               rsp_reg, rsp_next;

    logic [GIDX_W-1:0]  fidx;
    logic               free_ok;
    logic               alloc_ok;
    logic [WADDR_W-1:0] last_w;
    logic [BIT_W-1:0]   last_bit;
    logic [WORD_W-1:0]  lo_mask;
    logic [WORD_W-1:0]  hi_mask;
    logic [WORD_W-1:0]  avail;
    logic               found;
    logic [BIT_W-1:0]   found_bit;
    logic [GIDX_W-1:0]  gidx;
    logic [EFF_W-1:0]   eff_m1;

    assign fidx     = GIDX_W'(req.block_index);
    assign free_ok  = (req.block_index >= INDEX_W'(FIRST_USABLE)) &&
                      (EFF_W'(req.block_index) < eff_size);
    assign alloc_ok = eff_size > EFF_W'(FIRST_USABLE);
    assign eff_m1   = eff_size - EFF_W'(1);
    assign last_w   = WADDR_W'(eff_m1 >> BIT_W);
    assign last_bit = eff_m1[BIT_W-1:0];

    // bits of the checked word that lie inside the managed range
    assign lo_mask   = (chk_w_reg == '0) ? ~((WORD_W'(1) << FIRST_USABLE) - WORD_W'(1))
                                         : '1;
    assign hi_mask   = (chk_w_reg == last_w) ? ~({{(WORD_W-1){1'b1}}, 1'b0} << last_bit)
                                             : '1;
    assign avail     = ~rd_data & lo_mask & hi_mask;
    assign found     = avail != '0;
    assign found_bit = first_one(avail);
    assign gidx      = (GIDX_W'(chk_w_reg) << BIT_W) | GIDX_W'(found_bit);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (req.opcode == OP_FREE)
                    begin
                        state_next = free_ok ? S_FREE : S_IDLE;
                    end
                    else
                    begin
                        state_next = alloc_ok ? S_SCAN : S_IDLE;
                    end
                end
            end
            S_FREE:
            begin
                state_next = S_IDLE;
            end
            S_SCAN:
            begin
                if (chk_vld_reg && (found || chk_w_reg == last_w))
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rd_en        = 1'b0;
        rd_addr      = issue_reg[WADDR_W-1:0];
        wr_en        = 1'b0;
        wr_addr      = chk_w_reg;
        wr_data      = rd_data;
        fword_next   = fword_reg;
        fbit_next    = fbit_reg;
        issue_next   = issue_reg;
        chk_w_next   = chk_w_reg;
        chk_vld_next = 1'b0;
        done_next    = 1'b0;
        rsp_next     = rsp_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (req.opcode == OP_FREE)
                    begin
                        if (free_ok)
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = WADDR_W'(fidx >> BIT_W);
                            fword_next = WADDR_W'(fidx >> BIT_W);
                            fbit_next  = fidx[BIT_W-1:0];
                        end
                        else
                        begin
                            done_next = 1'b1;
                            rsp_next  = '{status: ST_BAD_INDEX, allocated_index: '0};
                        end
                    end
                    else
                    begin
                        if (alloc_ok)
                        begin
                            issue_next = '0;
                        end
                        else
                        begin
                            done_next = 1'b1;
                            rsp_next  = '{status: ST_NO_FREE, allocated_index: '0};
                        end
                    end
                end
            end
            S_FREE:
            begin
                wr_en     = 1'b1;
                wr_addr   = fword_reg;
                wr_data   = rd_data & ~(WORD_W'(1) << fbit_reg);
                done_next = 1'b1;
                rsp_next  = '{status: ST_OK, allocated_index: '0};
            end
            S_SCAN:
            begin
                // one word read per cycle, checked the cycle after
                if (issue_reg <= {1'b0, last_w})
                begin
                    rd_en        = 1'b1;
                    chk_vld_next = 1'b1;
                    chk_w_next   = issue_reg[WADDR_W-1:0];
                    issue_next   = issue_reg + (WADDR_W+1)'(1);
                end
                if (chk_vld_reg)
                begin
                    if (found)
                    begin
                        wr_en     = 1'b1;
                        wr_addr   = chk_w_reg;
                        wr_data   = rd_data | (WORD_W'(1) << found_bit);
                        done_next = 1'b1;
                        rsp_next  = '{status: ST_OK, allocated_index: gidx[INDEX_W-1:0]};
                    end
                    else if (chk_w_reg == last_w)
                    begin
                        done_next = 1'b1;
                        rsp_next  = '{status: ST_NO_FREE, allocated_index: '0};
                    end
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            chk_vld_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            chk_vld_reg <= chk_vld_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fword_reg <= fword_next;
        fbit_reg  <= fbit_next;
        issue_reg <= issue_next;
        chk_w_reg <= chk_w_next;
        rsp_reg   <= rsp_next;
    end

    assign busy = state_reg != S_IDLE;
    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

// ----- hdl/bitmap_block_allocator.sv -----
// first-fit bitmap block allocator, one used bit per block in 32-bit words
// command channel: a request (opcode, block_index) transfers on a rising edge
//   with start high and busy low; busy stays high while an accepted request is worked
// result channel: done pulses for one cycle with status and allocated_index;
//   the receiver cannot stall, the result must be taken in that cycle
// config channel: cfg_data (partition size) transfers when cfg_valid and
//   cfg_ready are high; cfg_ready is always high, write only while idle
// steps from the request to done:
//   rejected free, or allocate on a size of two or less: answered from idle
//   valid free: word read, then write back
//   allocate: the words covering the partition are read in order through the
//   single read port of the map memory, one word read per cycle, until a
//   free bit is found and set or the last word has been checked
// one request at a time; a new one may follow in the cycle done is high
// reset: map shows blocks 0 and 1 used and all others free, size is 512;
//   no clearing pass, per-word valid flags stand in for the reset value
module bitmap_block_allocator
    import bba_pkg::*;
#(
    parameter int MAX_BLOCKS = 512
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  req_t              req,
    output logic              done,
    output rsp_t              rsp,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [SIZE_W-1:0] cfg_data
);

    localparam int NUM_WORDS = (MAX_BLOCKS + WORD_W - 1) / WORD_W;
    localparam int WADDR_W   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int EFF_W     = ($clog2(MAX_BLOCKS + 1) > SIZE_W) ?
                               $clog2(MAX_BLOCKS + 1) : SIZE_W;

    logic [SIZE_W-1:0]  psize_reg;
    logic [EFF_W-1:0]   eff_size;
    logic               rd_en;
    logic [WADDR_W-1:0] rd_addr;
    logic [WORD_W-1:0]  rd_data;
    logic               wr_en;
    logic [WADDR_W-1:0] wr_addr;
    logic [WORD_W-1:0]  wr_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            psize_reg <= SIZE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            psize_reg <= cfg_data;
        end
    end

    // size clamped to the map
    assign eff_size = (EFF_W'(psize_reg) > EFF_W'(MAX_BLOCKS)) ? EFF_W'(MAX_BLOCKS)
                                                               : EFF_W'(psize_reg);

    bba_ctrl #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .req      (req),
        .eff_size (eff_size),
        .done     (done),
        .rsp      (rsp),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data)
    );

    bba_map_ram #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_map (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

endmodule
